// ===== rtl/tuple_interning_table_assert.svh =====
// ----------------------------------------------------------------------------
// tuple_interning_table_assert
// concurrent assertion macros shared by the tuple interning table modules
// ----------------------------------------------------------------------------
`ifndef TUPLE_INTERNING_TABLE_ASSERT_SVH
`define TUPLE_INTERNING_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TIT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define TIT_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition");
`else
`define TIT_ASSERT(label, clk, rst_n, prop)
`define TIT_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/tit_pkg.sv =====
// ----------------------------------------------------------------------------
// tit_pkg
// shared types and constants of the tuple interning table
// ----------------------------------------------------------------------------
`default_nettype none
package tit_pkg;
	localparam int MAX_COMPONENTS_DEF = 6;
	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int BUCKET_COUNT_DEF = 8192;
	localparam int VALUE_W = 32;
	localparam int LIMIT_W = 33;
	localparam int INDEX_W = 12;
	localparam int COUNT_W = 3;
	localparam int FIELD_COUNT = 6;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture item, update limits
		logic hash_step; // fold one component into the hash
		logic rd_bucket; // issue bucket read at probe pointer
		logic rd_entry;  // issue entry read for the bucket just read
		logic probe_next;
		logic insert_slot; // write entry and bucket, bump count
		logic set_found;
		logic set_new;
		logic set_full;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hash_last;
		logic slot_empty;
		logic slot_match;
		logic probes_done;
		logic table_at_depth;
	} dp_sts_t;
endpackage
`default_nettype wire

// ===== rtl/tit_datapath.sv =====
// ----------------------------------------------------------------------------
// tit_datapath
// item registers, hash, bucket and entry memories, limits and result register
// ----------------------------------------------------------------------------
`default_nettype none
module tit_datapath #(
	parameter int MAX_COMPONENTS = tit_pkg::MAX_COMPONENTS_DEF,
	parameter int TABLE_DEPTH = tit_pkg::TABLE_DEPTH_DEF,
	parameter int BUCKET_COUNT = tit_pkg::BUCKET_COUNT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tit_pkg::dp_cmd_t cmd,
	output tit_pkg::dp_sts_t sts,
	input  wire logic [tit_pkg::COUNT_W-1:0] count_cfg,
	input  wire logic [5:0] present_mask,
	input  wire logic [tit_pkg::FIELD_COUNT*tit_pkg::VALUE_W-1:0] values,
	output logic [tit_pkg::INDEX_W-1:0] entry_index,
	output logic is_new,
	output logic table_full,
	output logic [tit_pkg::FIELD_COUNT*tit_pkg::LIMIT_W-1:0] limits,
	output logic init_busy
);
	import tit_pkg::*;
	localparam int HW = $clog2(BUCKET_COUNT);
	localparam int EW = $clog2(TABLE_DEPTH);
	localparam int SW = EW + 1;
	localparam int CW = $clog2(MAX_COMPONENTS + 1);
	localparam int JW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int AW = EW + JW;

	logic [VALUE_W-1:0] tuple_q [MAX_COMPONENTS];
	logic [LIMIT_W-1:0] lim_q [FIELD_COUNT];
	logic [CW-1:0] n_q;
	logic [JW-1:0] j_q;
	logic [HW-1:0] h_q;
	logic [HW:0] probes_q;
	logic [SW-1:0] count_q;
	logic [SW-1:0] slot_q;
	logic [HW:0] clr_q;
	logic [SW-1:0] bucket_mem [BUCKET_COUNT];
	logic [VALUE_W*MAX_COMPONENTS-1:0] entry_mem [TABLE_DEPTH];
	logic [VALUE_W*MAX_COMPONENTS-1:0] entry_q;
	logic [VALUE_W*MAX_COMPONENTS-1:0] tuple_flat;
	logic [CW-1:0] n_eff;

	always_comb begin
		if (count_cfg == '0)
			n_eff = CW'(1);
		else if (32'(count_cfg) > MAX_COMPONENTS)
			n_eff = CW'(MAX_COMPONENTS);
		else
			n_eff = CW'(count_cfg);
	end

	always_comb begin
		for (int k = 0; k < MAX_COMPONENTS; k++)
			tuple_flat[k*VALUE_W +: VALUE_W] = tuple_q[k];
	end

	// bucket clearing pass after reset
	assign init_busy = !clr_q[HW];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (init_busy)
			clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (init_busy)
			bucket_mem[clr_q[HW-1:0]] <= (clr_q[HW-1:0] == '0) ? SW'(1) : '0;
		else if (cmd.insert_slot)
			bucket_mem[h_q] <= count_q + 1'b1;
		if (cmd.rd_bucket)
			slot_q <= bucket_mem[h_q];
	end

	// entry memory: row written whole, zero row at reset index 0 written on first pass
	always_ff @(posedge clk) begin
		if (init_busy && clr_q == '0)
			entry_mem[0] <= '0;
		else if (cmd.insert_slot)
			entry_mem[count_q[EW-1:0]] <= tuple_flat;
		if (cmd.rd_entry)
			entry_q <= entry_mem[EW'(slot_q - 1'b1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FIELD_COUNT; k++)
				lim_q[k] <= LIMIT_W'(1);
			for (int k = 0; k < MAX_COMPONENTS; k++)
				tuple_q[k] <= '0;
			count_q <= SW'(1);
			n_q <= CW'(1);
			j_q <= '0;
			h_q <= '0;
			probes_q <= '0;
			entry_index <= '0;
			is_new <= 1'b0;
			table_full <= 1'b0;
		end else begin
			if (cmd.load) begin
				n_q <= n_eff;
				j_q <= '0;
				h_q <= '0;
				probes_q <= '0;
				for (int k = 0; k < MAX_COMPONENTS; k++) begin
					if (k < 32'(n_eff) && present_mask[k]) begin
						tuple_q[k] <= values[k*VALUE_W +: VALUE_W];
						if ({1'b0, values[k*VALUE_W +: VALUE_W]} >= lim_q[k])
							lim_q[k] <= {1'b0, values[k*VALUE_W +: VALUE_W]} + 1'b1;
					end else begin
						tuple_q[k] <= '0;
					end
				end
			end
			if (cmd.hash_step) begin
				h_q <= HW'({h_q, 2'b00}) + HW'(tuple_q[j_q]);
				j_q <= j_q + 1'b1;
			end
			if (cmd.probe_next) begin
				h_q <= h_q + 1'b1;
				probes_q <= probes_q + 1'b1;
			end
			if (cmd.insert_slot)
				count_q <= count_q + 1'b1;
			if (cmd.set_found) begin
				entry_index <= INDEX_W'(slot_q - 1'b1);
				is_new <= 1'b0;
				table_full <= 1'b0;
			end
			if (cmd.set_new) begin
				entry_index <= INDEX_W'(count_q);
				is_new <= 1'b1;
				table_full <= 1'b0;
			end
			if (cmd.set_full) begin
				entry_index <= '0;
				is_new <= 1'b0;
				table_full <= 1'b1;
			end
		end
	end

	always_comb begin
		sts.hash_last = (CW'(j_q) + 1'b1) >= n_q;
		sts.slot_empty = (slot_q == '0);
		sts.slot_match = (entry_q == tuple_flat);
		sts.probes_done = probes_q[HW];
		sts.table_at_depth = (count_q == SW'(TABLE_DEPTH));
		for (int k = 0; k < FIELD_COUNT; k++)
			limits[k*LIMIT_W +: LIMIT_W] = lim_q[k];
	end

	`include "tuple_interning_table_assert.svh"
	`TIT_ASSERT(a_count_range, clk, arst_n, count_q >= SW'(1) && count_q <= SW'(TABLE_DEPTH))
	`TIT_ASSERT(a_insert_steps, clk, arst_n, cmd.insert_slot |=> count_q == $past(count_q) + 1'b1)
	`TIT_ASSERT_NEVER(a_write_in_init, clk, arst_n, init_busy && cmd.insert_slot)
endmodule
`default_nettype wire

// ===== rtl/tit_ctrl.sv =====
// ----------------------------------------------------------------------------
// tit_ctrl
// sequencer for hash, probe, compare and insert of one item
// ----------------------------------------------------------------------------
`default_nettype none
module tit_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire logic out_stall,
	input  wire logic init_busy,
	input  wire tit_pkg::dp_sts_t sts,
	output tit_pkg::dp_cmd_t cmd
);
	import tit_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_RDB = 3'd2;
	localparam logic [2:0] S_RDE = 3'd3;
	localparam logic [2:0] S_CMP = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic out_busy;
	logic accept;

	assign out_busy = out_valid && out_stall;
	assign in_stall = init_busy || (state_q != S_IDLE) || out_busy;
	assign accept = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_last)
					state_d = S_RDB;
			end
			S_RDB: begin
				if (sts.probes_done) begin
					cmd.set_full = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.rd_bucket = 1'b1;
					state_d = S_RDE;
				end
			end
			S_RDE: begin
				if (sts.slot_empty) begin
					if (sts.table_at_depth) begin
						cmd.set_full = 1'b1;
					end else begin
						cmd.set_new = 1'b1;
						cmd.insert_slot = 1'b1;
					end
					state_d = S_OUT;
				end else begin
					cmd.rd_entry = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.slot_match) begin
					cmd.set_found = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.probe_next = 1'b1;
					state_d = S_RDB;
				end
			end
			S_OUT: begin
				if (!out_busy)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && !out_busy)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	`include "tuple_interning_table_assert.svh"
	`TIT_ASSERT_NEVER(a_no_accept_busy, clk, arst_n, accept && state_q != S_IDLE)
	`TIT_ASSERT(a_load_hash, clk, arst_n, cmd.load |=> state_q == S_HASH)
	`TIT_ASSERT(a_one_result, clk, arst_n, $onehot0({cmd.set_new, cmd.set_found, cmd.set_full}))
endmodule
`default_nettype wire

// ===== rtl/tuple_interning_table.sv =====
// ----------------------------------------------------------------------------
// tuple_interning_table
// Each lookup first folds the n components in use into the hash one at a
// time, then for each bucket reads the bucket and, if it is occupied, reads
// its entry and compares it, moving on to the next bucket until a matching
// entry gives a hit, an empty bucket gives an insert, or a full table or an
// exhausted probe gives a full result; the result is then loaded into the
// output register. The next item is accepted at the earliest in the cycle
// the result leaves, so one item is handled at a time, and a stalled result
// holds off the next item. After reset a clearing pass over all BUCKET_COUNT
// buckets (8192 by default) runs before the first item is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module tuple_interning_table #(
	parameter int MAX_COMPONENTS = tit_pkg::MAX_COMPONENTS_DEF,
	parameter int TABLE_DEPTH = tit_pkg::TABLE_DEPTH_DEF,
	parameter int BUCKET_COUNT = tit_pkg::BUCKET_COUNT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [tit_pkg::COUNT_W-1:0] component_count,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [5:0] present_mask,
	input  wire logic [31:0] value0,
	input  wire logic [31:0] value1,
	input  wire logic [31:0] value2,
	input  wire logic [31:0] value3,
	input  wire logic [31:0] value4,
	input  wire logic [31:0] value5,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [11:0] entry_index,
	output logic is_new,
	output logic table_full,
	output logic [32:0] limit0,
	output logic [32:0] limit1,
	output logic [32:0] limit2,
	output logic [32:0] limit3,
	output logic [32:0] limit4,
	output logic [32:0] limit5
);
	import tit_pkg::*;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic init_busy;
	logic [COUNT_W-1:0] count_q;
	logic [FIELD_COUNT*LIMIT_W-1:0] limits;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= COUNT_W'(1);
		else if (cfg_valid && cfg_ready)
			count_q <= component_count;
	end

	tit_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .init_busy(init_busy),
		.sts(sts), .cmd(cmd)
	);

	tit_datapath #(
		.MAX_COMPONENTS(MAX_COMPONENTS), .TABLE_DEPTH(TABLE_DEPTH),
		.BUCKET_COUNT(BUCKET_COUNT)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .count_cfg(count_q),
		.present_mask(present_mask),
		.values({value5, value4, value3, value2, value1, value0}),
		.entry_index(entry_index), .is_new(is_new), .table_full(table_full),
		.limits(limits), .init_busy(init_busy)
	);

	assign limit0 = limits[0*LIMIT_W +: LIMIT_W];
	assign limit1 = limits[1*LIMIT_W +: LIMIT_W];
	assign limit2 = limits[2*LIMIT_W +: LIMIT_W];
	assign limit3 = limits[3*LIMIT_W +: LIMIT_W];
	assign limit4 = limits[4*LIMIT_W +: LIMIT_W];
	assign limit5 = limits[5*LIMIT_W +: LIMIT_W];
endmodule
`default_nettype wire

// ===== tb/sv/tuple_interning_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tuple_interning_checker
// watches the config, item and result channels, keeps its own copy of the
// hash table and value limits, and compares each result with the prediction
// ----------------------------------------------------------------------------
`default_nettype none
module tuple_interning_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	input  wire logic cfg_ready,
	input  wire logic [tit_pkg::COUNT_W-1:0] component_count,
	input  wire logic in_valid,
	input  wire logic in_stall,
	input  wire logic [5:0] present_mask,
	input  wire logic [31:0] value0,
	input  wire logic [31:0] value1,
	input  wire logic [31:0] value2,
	input  wire logic [31:0] value3,
	input  wire logic [31:0] value4,
	input  wire logic [31:0] value5,
	input  wire logic out_valid,
	input  wire logic out_stall,
	input  wire logic [11:0] entry_index,
	input  wire logic is_new,
	input  wire logic table_full,
	input  wire logic [32:0] limit0,
	input  wire logic [32:0] limit1,
	input  wire logic [32:0] limit2,
	input  wire logic [32:0] limit3,
	input  wire logic [32:0] limit4,
	input  wire logic [32:0] limit5,
	output int errors,
	output int pending,
	output int new_seen,
	output int full_seen,
	output int hits_seen
);
	import tit_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int BUCKETS = BUCKET_COUNT_DEF;

	typedef logic [VALUE_W-1:0] tuple_t [FIELD_COUNT];

	typedef struct {
		logic [INDEX_W-1:0] index;
		logic fresh;
		logic full;
		logic [LIMIT_W-1:0] lim [FIELD_COUNT];
	} lookup_t;

	logic [VALUE_W-1:0] stored [DEPTH][FIELD_COUNT];
	logic [12:0] slots [BUCKETS];
	int unsigned entries;
	logic [LIMIT_W-1:0] limits [FIELD_COUNT];
	logic [COUNT_W-1:0] count_reg;
	lookup_t lookup_q [$];

	function automatic int unsigned active_count();
		if (count_reg == 0) return 1;
		if (count_reg > MAX_COMPONENTS_DEF) return MAX_COMPONENTS_DEF;
		return 32'(count_reg);
	endfunction

	function automatic lookup_t intern_tuple(logic [5:0] mask, tuple_t vals);
		tuple_t t;
		int unsigned n, h, slot;
		logic hit, got_empty;
		lookup_t r;
		n = active_count();
		hit = 0;
		got_empty = 0;
		r.index = 0;
		r.fresh = 0;
		r.full = 0;
		for (int j = 0; j < FIELD_COUNT; j++) t[j] = '0;
		for (int j = 0; j < n; j++) begin
			if (mask[j]) begin
				t[j] = vals[j];
				if ({1'b0, vals[j]} >= limits[j]) limits[j] = {1'b0, vals[j]} + 33'd1;
			end
		end
		h = 0;
		for (int j = 0; j < n; j++) h = ((h << 2) + t[j]) & (BUCKETS - 1);
		for (int p = 0; p < BUCKETS; p++) begin
			slot = 32'(slots[h]);
			if (slot == 0) begin
				got_empty = 1;
				break;
			end
			if (slot - 1 < entries && stored[slot-1] == t) begin
				hit = 1;
				r.index = INDEX_W'(slot - 1);
				break;
			end
			h = (h + 1) & (BUCKETS - 1);
		end
		if (!hit) begin
			if (got_empty && entries < DEPTH) begin
				r.index = INDEX_W'(entries);
				stored[entries] = t;
				slots[h] = 13'(entries + 1);
				entries++;
				r.fresh = 1;
			end else begin
				r.full = 1;
			end
		end
		r.lim = limits;
		return r;
	endfunction

	assign pending = lookup_q.size();

	always @(posedge clk) begin
		tuple_t vals;
		lookup_t e;
		logic [LIMIT_W-1:0] got [FIELD_COUNT];
		logic bad;
		if (!arst_n) begin
			for (int b = 0; b < BUCKETS; b++) slots[b] = '0;
			slots[0] = 13'd1;
			for (int j = 0; j < FIELD_COUNT; j++) begin
				stored[0][j] = '0;
				limits[j] = 33'd1;
			end
			entries = 1;
			count_reg = 1;
			lookup_q.delete();
			errors = 0;
			new_seen = 0;
			full_seen = 0;
			hits_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) count_reg = component_count;
			if (in_valid && !in_stall) begin
				vals = '{value0, value1, value2, value3, value4, value5};
				lookup_q.insert(lookup_q.size(), intern_tuple(present_mask, vals));
			end
			if (out_valid && !out_stall) begin
				if (lookup_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result transaction idx=%0d", entry_index);
				end else begin
					e = lookup_q.pop_front();
					got = '{limit0, limit1, limit2, limit3, limit4, limit5};
					bad = entry_index !== e.index || is_new !== e.fresh || table_full !== e.full;
					for (int j = 0; j < FIELD_COUNT; j++) if (got[j] !== e.lim[j]) bad = 1;
					if (e.fresh) new_seen++;
					else if (e.full) full_seen++;
					else hits_seen++;
					if (bad) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: exp idx=%0d new=%0b full=%0b lim=%p",
								e.index, e.fresh, e.full, e.lim);
							$display("          got idx=%0d new=%0b full=%0b lim=%p",
								entry_index, is_new, table_full, got);
						end
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/tb_tuple_interning_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tuple_interning_table
// drives config writes and tuples with random gaps and output stalls; the
// checker predicts indexes, insert/full flags and value limits
// ----------------------------------------------------------------------------
`default_nettype none
module tb_tuple_interning_table;
	import tit_pkg::*;

	localparam int IDLE_PCT = 31;
	localparam int WATCHDOG = 100000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [COUNT_W-1:0] component_count = 1;
	logic in_valid = 0;
	logic in_stall;
	logic [5:0] present_mask = 0;
	logic [31:0] value0 = 0, value1 = 0, value2 = 0, value3 = 0, value4 = 0, value5 = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [11:0] entry_index;
	logic is_new, table_full;
	logic [32:0] limit0, limit1, limit2, limit3, limit4, limit5;
	int errors, pending, new_seen, full_seen, hits_seen;
	int items_sent = 0;
	int quiet_cycles = 0;
	logic no_idle = 0;

	// recently sent tuples, replayed to hit existing entries
	logic [5:0] hist_mask [$];
	logic [31:0] hist_val [$][FIELD_COUNT];

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	tuple_interning_table u_dut (.*);

	tuple_interning_checker u_checker (.*);

	always @(posedge clk) begin
		if (no_idle) out_stall <= 0;
		else out_stall <= ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
			|| !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		// reset clearing pass counts as quiet, so allow for it
		if (quiet_cycles > WATCHDOG) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_count(logic [COUNT_W-1:0] n);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1;
		component_count <= n;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_tuple(logic [5:0] m, logic [31:0] v [FIELD_COUNT]);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		present_mask <= m;
		{value0, value1, value2, value3, value4, value5} <= {v[0], v[1], v[2], v[3], v[4], v[5]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		hist_mask.insert(hist_mask.size(), m);
		hist_val.insert(hist_val.size(), v);
		if (hist_mask.size() > 64) begin
			void'(hist_mask.pop_front());
			void'(hist_val.pop_front());
		end
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(4))
			0: return 32'hFFFF_FFFF;
			1: return $urandom_range(3);
			2: return $urandom_range(40);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int cnt);
		logic [31:0] v [FIELD_COUNT];
		int k;
		for (int i = 0; i < cnt; i++) begin
			if (hist_mask.size() > 0 && $urandom_range(2) == 0) begin
				k = $urandom_range(hist_mask.size() - 1);
				send_tuple(hist_mask[k], hist_val[k]);
			end else begin
				foreach (v[j]) v[j] = rand_value();
				send_tuple($urandom_range(63), v);
			end
		end
	endtask

	initial begin
		logic [31:0] v [FIELD_COUNT];
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero tuple, extremes, masks, unused components
		v = '{default: 32'h0};
		send_tuple(6'h00, v);
		send_tuple(6'h3F, v);
		v = '{default: 32'hFFFF_FFFF};
		send_tuple(6'h3F, v);
		send_tuple(6'h3F, v);
		send_tuple(6'h00, v);
		v = '{32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6};
		send_tuple(6'h01, v);
		write_count(MAX_COMPONENTS_DEF);
		send_tuple(6'h3F, v);
		send_tuple(6'h15, v);
		send_tuple(6'h2A, v);
		v = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555};
		send_tuple(6'h3F, v);
		v = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA};
		send_tuple(6'h3F, v);
		// colliding hashes: 0x2000 folds to bucket 0
		v = '{32'h2000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
		send_tuple(6'h01, v);
		send_tuple(6'h01, v);
		write_count(0);
		send_tuple(6'h3F, v);
		write_count(7);
		send_tuple(6'h3F, v);
		write_count(3);
		v = '{32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6};
		send_tuple(6'h3F, v);
		send_tuple(6'h07, v);

		random_phase(300);
		write_count(1);
		random_phase(150);
		no_idle = 1;
		random_phase(200);
		no_idle = 0;
		// sender holds off until the table has answered everything
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		write_count(6);
		random_phase(583);
		write_count(2);
		random_phase(100);
		write_count(4);
		random_phase(100);

		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d tuples: %0d inserts, %0d hits, %0d full rejects",
			items_sent, new_seen, hits_seen, full_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

// ===== tuple_interning_table.f =====
+incdir+rtl
rtl/tit_pkg.sv
rtl/tit_datapath.sv
rtl/tit_ctrl.sv
rtl/tuple_interning_table.sv
tb/sv/tuple_interning_checker.sv
tb/sv/tb_tuple_interning_table.sv
